@@ rtl/olr_pkg.sv @@
// Package for the ordered list block: widths, action and result codes,
// command and status structs shared by the controller and the datapath.
// No dependencies.
package olr_pkg;

    localparam int VALUE_W        = 64;
    localparam int LIST_DEPTH_DEF = 32;

    typedef logic [1:0]                t_action;
    typedef logic [2:0]                t_kind;
    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_action ACT_APPEND = 2'd0;
    localparam t_action ACT_REMOVE = 2'd1;
    localparam t_action ACT_DRAIN  = 2'd2;

    localparam t_kind KIND_OK        = 3'd0;
    localparam t_kind KIND_NOT_FOUND = 3'd1;
    localparam t_kind KIND_FULL      = 3'd2;
    localparam t_kind KIND_DATA      = 3'd3;
    localparam t_kind KIND_EMPTY     = 3'd4;
    localparam t_kind KIND_ERROR     = 3'd5;

    localparam t_value MARKER = '1;

    typedef struct packed {
        logic in_ready;
        logic compare;
        logic do_append;
        logic do_remove;
        logic do_drain;
    } t_cmd;

    typedef struct packed {
        logic    in_fire;
        t_action in_action;
        t_action item_action;
        logic    out_free;
        logic    drain_done;
    } t_status;

endpackage

@@ rtl/olr_if.sv @@
// Channel interfaces for the ordered list block: input items and results.
// Depends on olr_pkg.
interface olr_in_if import olr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_action action;
    t_value  item_value;

    modport source (output valid, output action, output item_value, input ready);
    modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface olr_out_if import olr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_value out_value;
    logic   last;

    modport source (output valid, output kind, output out_value, output last, input ready);
    modport sink   (input valid, input kind, input out_value, input last, output ready);
endinterface

@@ rtl/olr_dpath.sv @@
// Datapath of the ordered list: row of entry cells with parallel compare,
// compacting shift, entry count and the result register.
// Depends on olr_pkg and olr_if.
module olr_dpath import olr_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olr_in_if.sink    i_in,
    olr_out_if.source o_out,
    input  t_cmd      i_cmd,
    output t_status   o_status
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    t_value                r_cell [LIST_DEPTH];
    t_value                w_up   [LIST_DEPTH];
    logic [CW-1:0]         r_count;
    t_action               r_action;
    t_value                r_value;
    logic [LIST_DEPTH-1:0] r_match;
    logic [LIST_DEPTH-1:0] w_live;
    logic [LIST_DEPTH-1:0] w_eq;
    logic [LIST_DEPTH-1:0] w_below;
    logic [LIST_DEPTH-1:0] w_shift;
    logic                  w_found;
    logic                  w_full;
    logic                  w_cnt_zero;
    logic                  w_head_marker;
    logic                  w_last_entry;
    logic                  w_push;
    logic                  w_drain_data;
    t_value                w_push_val;
    logic                  r_out_valid;
    t_kind                 r_out_kind;
    t_value                r_out_value;
    logic                  r_out_last;
    t_kind                 n_kind;
    t_value                n_value;
    logic                  n_last;
    logic [CW-1:0]         n_count;

    assign i_in.ready = i_cmd.in_ready;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        assign w_live[g] = CW'(g) < r_count;
        assign w_eq[g]   = w_live[g] && (r_cell[g] == r_value);
        if (g < LIST_DEPTH - 1) begin : g_up
            assign w_up[g] = r_cell[g+1];
        end else begin : g_top
            assign w_up[g] = r_cell[g];
        end
    end

    assign w_found       = |r_match;
    assign w_below       = (r_match - LIST_DEPTH'(1)) & ~r_match;
    assign w_full        = r_count == CW'(LIST_DEPTH);
    assign w_cnt_zero    = r_count == '0;
    assign w_last_entry  = r_count == CW'(1);
    assign w_head_marker = r_cell[0] == MARKER;
    assign w_push        = i_cmd.do_append || (i_cmd.do_remove && !w_found);
    assign w_push_val    = i_cmd.do_append ? r_value : MARKER;
    assign w_drain_data  = i_cmd.do_drain && !w_cnt_zero && !w_head_marker;
    assign w_shift       = w_drain_data ? '1 :
                           (i_cmd.do_remove && w_found) ? ~w_below : '0;

    always_comb begin
        n_kind  = KIND_OK;
        n_value = '0;
        n_last  = 1'b1;
        n_count = r_count;
        if (w_push) begin
            if (w_full) begin
                n_kind = KIND_FULL;
            end else begin
                n_kind  = i_cmd.do_append ? KIND_OK : KIND_NOT_FOUND;
                n_count = r_count + CW'(1);
            end
        end else if (i_cmd.do_remove) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.do_drain) begin
            priority if (w_cnt_zero) begin
                n_kind = KIND_EMPTY;
            end else if (w_head_marker) begin
                n_kind = KIND_ERROR;
            end else begin
                n_kind  = KIND_DATA;
                n_value = r_cell[0];
                n_last  = w_last_entry;
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_shift[i]) begin
                r_cell[i] <= w_up[i];
            end else if (w_push && !w_full && CW'(i) == r_count) begin
                r_cell[i] <= w_push_val;
            end
        end
        if (o_status.in_fire) begin
            r_action <= i_in.action;
            r_value  <= i_in.item_value;
        end
        if (i_cmd.compare) begin
            r_match <= w_eq;
        end
        if (i_cmd.do_append || i_cmd.do_remove || i_cmd.do_drain) begin
            r_out_kind  <= n_kind;
            r_out_value <= n_value;
            r_out_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.do_append || i_cmd.do_remove || i_cmd.do_drain) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_out_kind;
    assign o_out.out_value = r_out_value;
    assign o_out.last      = r_out_last;

    assign o_status.in_fire     = i_in.valid && i_cmd.in_ready;
    assign o_status.in_action   = i_in.action;
    assign o_status.item_action = r_action;
    assign o_status.out_free    = !r_out_valid || o_out.ready;
    assign o_status.drain_done  = w_cnt_zero || w_head_marker || w_last_entry;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_match_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_remove |-> (r_match & ~w_live) == '0)
        else $error("match outside live entries");

    a_drain_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drain_data |=> r_count == $past(r_count) - CW'(1))
        else $error("drain step did not pop head");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_append || i_cmd.do_remove || i_cmd.do_drain) |-> o_status.out_free)
        else $error("result written over pending transaction");

endmodule

@@ rtl/olr_ctrl.sv @@
// Controller of the ordered list: sequences compare, update and drain steps
// and paces them against the result register.
// Depends on olr_pkg.
module olr_ctrl import olr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_fire) begin
                    unique case (i_status.in_action)
                        ACT_APPEND: n_state = ST_EXEC;
                        ACT_REMOVE: n_state = ST_CMP;
                        ACT_DRAIN:  n_state = ST_DRAIN;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.do_append = i_status.item_action == ACT_APPEND;
                    o_cmd.do_remove = i_status.item_action == ACT_REMOVE;
                    n_state         = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.do_drain = 1'b1;
                    if (i_status.drain_done) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/ordered_list_remove_by_value.sv @@
// Ordered list of signed 64-bit entries with append, remove by value and drain.
// Input channel i_in carries action and item_value; result channel o_out
// carries kind, out_value and last (set on the final result of a transaction).
// Append: the item is registered, then appended and its result registered.
// Remove: a parallel compare across all cells, then a step that compacts
// the row or appends the marker. Drain: one result per cycle while the
// result register is free, one entry popped per data result, ending at an
// empty list, a marker entry (error result) or a single empty result.
// One item is in flight at a time: i_in.ready is high only while the
// controller is idle, so a new item is taken only after the last one has
// issued its final result. A result waits in the output register while
// o_out.ready is low; the block then issues no further result until that
// one leaves. Action code 3 is accepted and gives no result.
// Reset (i_rst_n low at a clock edge) empties the list and drops any pending
// result; entry contents are left as they are.
// Depends on olr_pkg, olr_if, olr_ctrl and olr_dpath.
module ordered_list_remove_by_value import olr_pkg::*; #(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olr_in_if.sink    i_in,
    olr_out_if.source o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    olr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    olr_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule
